### rtl/ibfr_pkg.sv
// ibfr_pkg: constants, types and state encoding for the iBus frame receiver.
// No dependencies; all rtl files but ibfr_chan_ram refer to it by scoped names.
package ibfr_pkg;

    // Frame layout: header 0x20 0x40, fourteen LE words, LE checksum.
    localparam int unsigned FRAME_WORDS    = 14;
    localparam int unsigned CHANNELS       = 14;
    localparam int unsigned FRAME_AW       = $clog2(FRAME_WORDS);
    localparam int unsigned POS_W          = 5;
    localparam int unsigned IDX_W          = 4;

    localparam logic [7:0]  HDR_LEN_BYTE   = 8'h20;
    localparam logic [7:0]  HDR_CMD_BYTE   = 8'h40;
    localparam logic [16:0] SUM_TARGET     = 17'h0_FFFF;

    localparam logic [POS_W-1:0] POS_HUNT       = POS_W'(0);
    localparam logic [POS_W-1:0] POS_GOT_LEN    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CSUM_LO    = POS_W'(2 + 2 * FRAME_WORDS);

    localparam logic [IDX_W-1:0] LAST_INDEX     = IDX_W'(CHANNELS - 1);

    // Write request from the parser to the channel store.
    typedef struct packed {
        logic                en;
        logic [FRAME_AW-1:0] addr;
        logic [15:0]         data;
    } t_wr_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_emit_state;

endpackage

### rtl/ibus_frame_receiver.sv
// ibus_frame_receiver: streaming parser for 14-channel iBus RC frames.
// Depends on ibfr_pkg, ibfr_chan_ram, ibfr_parser and ibfr_emitter.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+--------------------------------------
//   rx      | in        | i_valid/o_stall  | i_rx_byte
//   result  | out       | o_valid/i_stall  | o_channel_index, o_channel_value,
//           |           |                  | o_last_channel
//
// Flow: each received word is taken while i_valid is high and o_stall is low; the
// parser works on it in that same cycle. A frame whose checksum holds is read
// back from the channel store word by word, each word with one store read and
// then one output load; stalls on the result side hold the burst.
// Stalls: o_stall is high for the whole burst, driven by the emitter's busy state.
// Reset: synchronous, active low; the parser returns to header hunting and the
// output register is emptied. The channel store is not cleared.
module ibus_frame_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ibfr_pkg::IDX_W-1:0] o_channel_index,
    output logic [15:0]                o_channel_value,
    output logic                       o_last_channel
);

    ibfr_pkg::t_wr_req              wr;
    logic                           frame_ok;
    logic                           busy;
    logic                           rd_en;
    logic [ibfr_pkg::FRAME_AW-1:0]  rd_addr;
    logic [15:0]                    rd_data;
    logic                           in_accept;

    // Hold the input off while a frame's channel words are being drained.
    assign o_stall   = busy;
    assign in_accept = i_valid && !busy;

    ibfr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_rx_byte  (i_rx_byte),
        .o_wr       (wr),
        .o_frame_ok (frame_ok)
    );

    // Channel words of the frame in progress; written by the parser, read back
    // by the emitter only after the checksum byte, so accesses never overlap.
    ibfr_chan_ram #(
        .DEPTH (ibfr_pkg::FRAME_WORDS),
        .WIDTH (16)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ibfr_emitter u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_ok      (frame_ok),
        .i_out_stall     (i_stall),
        .i_rd_data       (rd_data),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

### rtl/ibfr_chan_ram.sv
// ibfr_chan_ram: generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module ibfr_chan_ram #(
    parameter int unsigned DEPTH = 14,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ibfr_parser.sv
// ibfr_parser: header hunt, byte sum, word assembly and checksum test.
// Depends on ibfr_pkg; drives the channel store write port.
module ibfr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    output ibfr_pkg::t_wr_req   o_wr,
    output logic                o_frame_ok
);

    logic [ibfr_pkg::POS_W-1:0] r_pos;
    logic [ibfr_pkg::POS_W-1:0] n_pos;
    logic [15:0]                r_sum;
    logic [15:0]                n_sum;
    logic [7:0]                 r_held;
    logic [7:0]                 n_held;
    logic [ibfr_pkg::POS_W-1:0] off;
    logic [16:0]                total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= ibfr_pkg::POS_HUNT;
            r_sum  <= '0;
            r_held <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_held <= n_held;
        end
    end

    assign off   = r_pos - ibfr_pkg::POS_FIRST_DATA;
    assign total = {1'b0, r_sum} + {1'b0, i_rx_byte, r_held};

    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_held     = r_held;
        o_wr.en    = 1'b0;
        o_wr.addr  = off[ibfr_pkg::FRAME_AW:1];
        o_wr.data  = {i_rx_byte, r_held};
        o_frame_ok = 1'b0;
        if (i_accept) begin
            if (r_pos == ibfr_pkg::POS_HUNT) begin
                if (i_rx_byte == ibfr_pkg::HDR_LEN_BYTE) begin
                    n_pos = ibfr_pkg::POS_GOT_LEN;
                end
            end else if (r_pos == ibfr_pkg::POS_GOT_LEN) begin
                if (i_rx_byte == ibfr_pkg::HDR_CMD_BYTE) begin
                    n_sum = 16'({8'h00, ibfr_pkg::HDR_LEN_BYTE})
                          + 16'({8'h00, ibfr_pkg::HDR_CMD_BYTE});
                    n_pos = ibfr_pkg::POS_FIRST_DATA;
                end else if (i_rx_byte == ibfr_pkg::HDR_LEN_BYTE) begin
                    n_pos = ibfr_pkg::POS_GOT_LEN;
                end else begin
                    n_pos = ibfr_pkg::POS_HUNT;
                end
            end else if (r_pos < ibfr_pkg::POS_CSUM_LO) begin
                n_sum = r_sum + {8'h00, i_rx_byte};
                if (!off[0]) begin
                    n_held = i_rx_byte;
                end else begin
                    o_wr.en = 1'b1;
                end
                n_pos = r_pos + ibfr_pkg::POS_W'(1);
            end else if (r_pos == ibfr_pkg::POS_CSUM_LO) begin
                n_held = i_rx_byte;
                n_pos  = r_pos + ibfr_pkg::POS_W'(1);
            end else begin
                // checksum high byte: sum plus checksum must hit 0xFFFF exactly
                o_frame_ok = (total == ibfr_pkg::SUM_TARGET);
                n_pos      = ibfr_pkg::POS_HUNT;
            end
        end
    end

endmodule

### rtl/ibfr_emitter.sv
// ibfr_emitter: reads the channel store word by word into the output register.
// Depends on ibfr_pkg; drives the store read port and the result channel.
module ibfr_emitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_frame_ok,
    input  logic                          i_out_stall,
    input  logic [15:0]                   i_rd_data,
    output logic                          o_rd_en,
    output logic [ibfr_pkg::FRAME_AW-1:0] o_rd_addr,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [ibfr_pkg::IDX_W-1:0]    o_channel_index,
    output logic [15:0]                   o_channel_value,
    output logic                          o_last_channel
);

    ibfr_pkg::t_emit_state          r_state;
    ibfr_pkg::t_emit_state          n_state;
    logic [ibfr_pkg::IDX_W-1:0]     r_idx;
    logic [ibfr_pkg::IDX_W-1:0]     n_idx;
    logic                           r_valid;
    logic                           n_valid;
    logic [ibfr_pkg::IDX_W-1:0]     r_index;
    logic [ibfr_pkg::IDX_W-1:0]     n_index;
    logic [15:0]                    r_value;
    logic [15:0]                    n_value;
    logic                           r_last;
    logic                           n_last;
    logic                           out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibfr_pkg::ST_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index <= n_index;
        r_value <= n_value;
        r_last  <= n_last;
    end

    assign out_free = !r_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_valid   = r_valid && i_out_stall;
        n_index   = r_index;
        n_value   = r_value;
        n_last    = r_last;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[ibfr_pkg::FRAME_AW-1:0];
        case (r_state)
            ibfr_pkg::ST_IDLE: begin
                n_idx = '0;
                if (i_frame_ok) begin
                    n_state = ibfr_pkg::ST_EMIT_RD;
                end
            end
            ibfr_pkg::ST_EMIT_RD: begin
                // issue the read only once the output register will be empty
                if (out_free) begin
                    o_rd_en = 1'b1;
                    n_state = ibfr_pkg::ST_EMIT_LD;
                end
            end
            ibfr_pkg::ST_EMIT_LD: begin
                n_valid = 1'b1;
                n_index = r_idx;
                n_value = i_rd_data;
                n_last  = (r_idx == ibfr_pkg::LAST_INDEX);
                if (r_idx == ibfr_pkg::LAST_INDEX) begin
                    n_state = ibfr_pkg::ST_IDLE;
                end else begin
                    n_idx   = r_idx + ibfr_pkg::IDX_W'(1);
                    n_state = ibfr_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ibfr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy          = (r_state != ibfr_pkg::ST_IDLE);
    assign o_valid         = r_valid;
    assign o_channel_index = r_index;
    assign o_channel_value = r_value;
    assign o_last_channel  = r_last;

endmodule

### rtl/ibfr_checker.sv
// ibfr_checker: port-level assertions for ibus_frame_receiver, bound to the top.
// Depends on ibfr_pkg.
module ibfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [ibfr_pkg::IDX_W-1:0] o_channel_index,
    input logic [15:0]                o_channel_value,
    input logic                       o_last_channel
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_channel_index)
            && $stable(o_channel_value) && $stable(o_last_channel))
        else $error("stalled result word changed");

    // The last flag marks exactly the final channel index.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_channel |-> o_channel_index == ibfr_pkg::LAST_INDEX)
        else $error("last flag on wrong channel index");

    a_mid_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_channel |-> o_channel_index < ibfr_pkg::LAST_INDEX)
        else $error("channel index beyond frame");

    // Mid-burst, input stays blocked.
    a_burst_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_channel |-> o_stall)
        else $error("input open during channel burst");

    // No result straight after the last one of a frame is taken.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_channel |=> !o_valid)
        else $error("result word right after end of frame");

endmodule

bind ibus_frame_receiver ibfr_checker u_ibfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_channel_index (o_channel_index),
    .o_channel_value (o_channel_value),
    .o_last_channel  (o_last_channel)
);

### tb/sv/ibus_frame_receiver_tb.sv
// ibus_frame_receiver_tb: self-checking bench for the iBus frame receiver.
// Streams header, frame and noise bytes into the block and checks every channel word.
// Depends on ibfr_pkg and the ibus_frame_receiver rtl.
module ibus_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Follows the frame parse on its own and queues the channel words due from each
    // frame whose checksum holds. Mismatches are counted here too.
    class ChannelWordTracker;
        typedef struct {
            logic [ibfr_pkg::IDX_W-1:0] index;
            logic [15:0]                value;
            logic                       last;
        } t_chan_word;

        logic [ibfr_pkg::POS_W-1:0] position = ibfr_pkg::POS_HUNT;
        logic [15:0]                running_sum = '0;
        logic [7:0]                 low_byte = '0;
        logic [15:0]                frame_words [ibfr_pkg::FRAME_WORDS];
        t_chan_word                 awaited_channels [$];
        int                         mismatches = 0;

        task report_mismatch(input string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        function int outstanding();
            return awaited_channels.size();
        endfunction

        // Advance the parse by one received byte.
        function void take_rx_byte(input logic [7:0] rx);
            logic [ibfr_pkg::POS_W-1:0] offset;
            logic [16:0] total;
            t_chan_word  due;
            if (position == ibfr_pkg::POS_HUNT) begin
                if (rx == ibfr_pkg::HDR_LEN_BYTE)
                    position = ibfr_pkg::POS_GOT_LEN;
            end else if (position == ibfr_pkg::POS_GOT_LEN) begin
                if (rx == ibfr_pkg::HDR_CMD_BYTE) begin
                    running_sum = 16'(ibfr_pkg::HDR_LEN_BYTE) + 16'(ibfr_pkg::HDR_CMD_BYTE);
                    position    = ibfr_pkg::POS_FIRST_DATA;
                end else if (rx != ibfr_pkg::HDR_LEN_BYTE) begin
                    position = ibfr_pkg::POS_HUNT;
                end
            end else if (position < ibfr_pkg::POS_CSUM_LO) begin
                offset      = position - ibfr_pkg::POS_FIRST_DATA;
                running_sum = running_sum + 16'(rx);
                if (offset[0] == 1'b0)
                    low_byte = rx;
                else
                    frame_words[offset[ibfr_pkg::FRAME_AW:1]] = {rx, low_byte};
                position = position + ibfr_pkg::POS_W'(1);
            end else if (position == ibfr_pkg::POS_CSUM_LO) begin
                low_byte = rx;
                position = position + ibfr_pkg::POS_W'(1);
            end else begin
                total = 17'(running_sum) + 17'({rx, low_byte});
                if (total == ibfr_pkg::SUM_TARGET) begin
                    for (int i = 0; i < ibfr_pkg::CHANNELS; i++) begin
                        due.index = ibfr_pkg::IDX_W'(i);
                        due.value = frame_words[i];
                        due.last  = (due.index == ibfr_pkg::LAST_INDEX);
                        awaited_channels.push_back(due);
                    end
                end
                position = ibfr_pkg::POS_HUNT;
            end
        endfunction

        task check_channel_word(input logic [ibfr_pkg::IDX_W-1:0] index,
                                input logic [15:0] value, input logic last);
            t_chan_word due;
            if (awaited_channels.size() == 0) begin
                report_mismatch($sformatf("unexpected channel word idx=%0d value=%h",
                                          index, value));
            end else begin
                due = awaited_channels.pop_front();
                if (index !== due.index)
                    report_mismatch($sformatf("channel_index %0d, want %0d", index,
                                              due.index));
                if (value !== due.value)
                    report_mismatch($sformatf("channel_value %h, want %h (idx %0d)", value,
                                              due.value, due.index));
                if (last !== due.last)
                    report_mismatch($sformatf("last_channel %b, want %b (idx %0d)", last,
                                              due.last, due.index));
            end
        endtask

        task flag_leftovers();
            if (awaited_channels.size() != 0)
                report_mismatch($sformatf("%0d channel words never arrived",
                                          awaited_channels.size()));
        endtask
    endclass

    localparam int RANDOM_RX_WORDS = 96;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 64;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [7:0]                 i_rx_byte;
    logic                       o_valid;
    logic                       i_stall;
    logic [ibfr_pkg::IDX_W-1:0] o_channel_index;
    logic [15:0]                o_channel_value;
    logic                       o_last_channel;

    ChannelWordTracker tracker = new();

    // Shared between the sender and the receiver: steady_run switches random idling off
    // on both sides, hold_off_req asks the receiver for one long hold-off.
    bit steady_run   = 1'b0;
    bit hold_off_req = 1'b0;
    int rx_words_taken = 0;
    logic [15:0] frame_content [ibfr_pkg::FRAME_WORDS];

    ibus_frame_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Offer one word on the rx channel. Inputs move only at the falling edge; the word
    // is held until a rising edge sees the block not stalling. Valid is left high on
    // return so that back-to-back words need no second assignment in one step.
    task automatic send_rx_word(input logic [7:0] rx);
        @(negedge i_clk);
        while (!steady_run && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        tracker.take_rx_byte(rx);
        rx_words_taken++;
    endtask

    // Send a whole frame: header, fourteen little-endian words, then the checksum.
    // A non-zero csum_flip spoils the checksum by exactly those bits.
    task automatic send_frame(input logic [15:0] csum_flip);
        logic [15:0] sum;
        logic [15:0] csum;
        sum = 16'(ibfr_pkg::HDR_LEN_BYTE) + 16'(ibfr_pkg::HDR_CMD_BYTE);
        send_rx_word(ibfr_pkg::HDR_LEN_BYTE);
        send_rx_word(ibfr_pkg::HDR_CMD_BYTE);
        for (int i = 0; i < ibfr_pkg::FRAME_WORDS; i++) begin
            send_rx_word(frame_content[i][7:0]);
            send_rx_word(frame_content[i][15:8]);
            sum = sum + 16'(frame_content[i][7:0]) + 16'(frame_content[i][15:8]);
        end
        csum = (16'hFFFF - sum) ^ csum_flip;
        send_rx_word(csum[7:0]);
        send_rx_word(csum[15:8]);
    endtask

    // Channel words lean towards the extremes and towards header bytes hidden in data.
    function automatic logic [15:0] pick_channel_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {ibfr_pkg::HDR_CMD_BYTE, ibfr_pkg::HDR_LEN_BYTE};
            3:       return {ibfr_pkg::HDR_LEN_BYTE, ibfr_pkg::HDR_LEN_BYTE};
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(3))
            0:       return ibfr_pkg::HDR_LEN_BYTE;
            1:       return ibfr_pkg::HDR_CMD_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic fill_random_frame();
        for (int i = 0; i < ibfr_pkg::FRAME_WORDS; i++)
            frame_content[i] = pick_channel_word();
    endtask

    // Drop valid and hold the sender until every due channel word has come out.
    task automatic drain_channel_words();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Result side: random stalls, none during the steady stretch, and one long hold-off
    // counted here so that the block fills up and stalls its rx channel.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left--;
            end else if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !steady_run && ($urandom_range(99) < 31);
            end
        end
    end

    // Check every channel word taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && !i_stall) begin
            if ($isunknown(o_valid))
                tracker.report_mismatch("o_valid unknown");
            else if (o_valid)
                tracker.check_channel_word(o_channel_index, o_channel_value,
                                           o_last_channel);
        end
    end

    initial begin
        #2ms;
        $display("ibus_frame_receiver test failed");
        $finish;
    end

    initial begin
        int step;
        int word_goal;
        int noise_len;
        int pick;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_rx_byte = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stray bytes, a header broken by another byte, a repeated length
        // byte before the command byte, then a frame that opens with extreme and header-like words.
        send_rx_word(8'h00);
        send_rx_word(8'hFF);
        send_rx_word(ibfr_pkg::HDR_CMD_BYTE);
        send_rx_word(ibfr_pkg::HDR_LEN_BYTE);
        send_rx_word(8'h55);
        send_rx_word(ibfr_pkg::HDR_LEN_BYTE);
        fill_random_frame();
        frame_content[0] = 16'h0000;
        frame_content[1] = 16'hFFFF;
        frame_content[2] = {ibfr_pkg::HDR_CMD_BYTE, ibfr_pkg::HDR_LEN_BYTE};
        frame_content[3] = 16'h8001;
        frame_content[4] = 16'h7FFE;
        frame_content[5] = {8'h00, ibfr_pkg::HDR_LEN_BYTE};
        send_frame(16'h0000);

        // All-ones frame with a checksum one off, then the same frame intact, then
        // an all-zero frame.
        foreach (frame_content[i]) frame_content[i] = 16'hFFFF;
        send_frame(16'h0001);
        send_frame(16'h0000);
        foreach (frame_content[i]) frame_content[i] = 16'h0000;
        send_frame(16'h0000);

        // Random: mostly intact frames with random content, some spoilt checksums,
        // noise and frames cut short, which leave the parser out of step.
        word_goal = rx_words_taken + RANDOM_RX_WORDS;
        step = 0;
        while (rx_words_taken < word_goal) begin
            steady_run = (step == 0);
            if (step == 1)
                hold_off_req = 1'b1;
            if (step == 2)
                drain_channel_words();
            pick = (step < 2) ? 0 : $urandom_range(99);
            if (pick < 62) begin
                fill_random_frame();
                send_frame(16'h0000);
            end else if (pick < 76) begin
                fill_random_frame();
                send_frame(16'($urandom_range(1, 16'hFFFF)));
            end else if (pick < 92) begin
                noise_len = $urandom_range(1, 5);
                repeat (noise_len) send_rx_word(pick_noise_byte());
            end else begin
                send_rx_word(ibfr_pkg::HDR_LEN_BYTE);
                send_rx_word(ibfr_pkg::HDR_CMD_BYTE);
                noise_len = $urandom_range(1, 20);
                repeat (noise_len) send_rx_word(8'($urandom_range(255)));
            end
            step++;
        end
        steady_run = 1'b0;

        drain_channel_words();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        tracker.flag_leftovers();
        if (tracker.mismatches == 0)
            $display("ibus_frame_receiver test passed");
        else
            $display("ibus_frame_receiver test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ibfr_pkg.sv
rtl/ibfr_chan_ram.sv
rtl/ibfr_parser.sv
rtl/ibfr_emitter.sv
rtl/ibus_frame_receiver.sv
rtl/ibfr_checker.sv
tb/sv/ibus_frame_receiver_tb.sv
